// ===== rtl/mtd_pkg.sv =====
// Shared types, character codes and the Morse code table for the token decoder.
// No dependencies; every file but mtd_stream_if imports this package.
package mtd_pkg;

  localparam int MAX_SYMBOLS_DEF = 5;
  localparam int TABLE_SYMBOLS   = 5;
  localparam int IDX_W           = TABLE_SYMBOLS + 1;

  localparam logic [7:0] CHAR_DOT     = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_DASH    = 8'h3D;  // '='
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_INVALID = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_NONE    = 8'h00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] decoded_char;
    logic       invalid_token;
  } out_item_t;

  typedef enum logic [1:0] {
    TOK_SPACE,
    TOK_CODE,
    TOK_INVALID
  } tok_kind_t;

  // One finished token, as handed from the front end to the back end.
  typedef struct packed {
    tok_kind_t        kind;
    logic [IDX_W-1:0] code_idx;
  } tok_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic halted;
  } front_stat_t;

  // Index is (1 << length) + bits, first symbol highest, dash = 1.
  function automatic logic [7:0] code_char(input logic [IDX_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      6'd2:    ch = "E";
      6'd3:    ch = "T";
      6'd4:    ch = "I";
      6'd5:    ch = "A";
      6'd6:    ch = "N";
      6'd7:    ch = "M";
      6'd8:    ch = "S";
      6'd9:    ch = "U";
      6'd10:   ch = "R";
      6'd11:   ch = "W";
      6'd12:   ch = "D";
      6'd13:   ch = "K";
      6'd14:   ch = "G";
      6'd15:   ch = "O";
      6'd16:   ch = "H";
      6'd17:   ch = "V";
      6'd18:   ch = "F";
      6'd20:   ch = "L";
      6'd22:   ch = "P";
      6'd23:   ch = "J";
      6'd24:   ch = "B";
      6'd25:   ch = "X";
      6'd26:   ch = "C";
      6'd27:   ch = "Y";
      6'd28:   ch = "Z";
      6'd29:   ch = "Q";
      6'd32:   ch = "5";
      6'd33:   ch = "4";
      6'd35:   ch = "3";
      6'd39:   ch = "2";
      6'd47:   ch = "1";
      6'd48:   ch = "6";
      6'd56:   ch = "7";
      6'd60:   ch = "8";
      6'd62:   ch = "9";
      6'd63:   ch = "0";
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/mtd_stream_if.sv =====
// Valid/ready stream channel carrying one word of a given payload type.
// No dependencies; payload types come from mtd_pkg at the point of use.
interface mtd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/mtd_front.sv =====
// Front end: classifies text bytes, builds the current token and emits finished tokens.
// Depends on mtd_pkg and mtd_stream_if.
module mtd_front #(
  parameter int MAX_SYMBOLS = mtd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  mtd_stream_if.sink           text,
  input  mtd_pkg::q_stat_t     q_stat,
  output logic                 q_push,
  output mtd_pkg::tok_entry_t  q_data,
  output mtd_pkg::front_stat_t f_stat
);
  import mtd_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 2);

  logic [MAX_SYMBOLS-1:0] symbol_bits, symbol_bits_next;
  logic [CNT_W-1:0]       symbol_count, symbol_count_next;
  logic                   bad_char_seen, bad_char_seen_next;
  logic                   slash_seen, slash_seen_next;
  logic                   halted;

  logic       fire, last, is_ws, is_dot, is_dash, is_slash;
  logic       do_finish, pending, in_table;
  logic [7:0] c;
  logic [IDX_W-1:0] idx;
  tok_kind_t  kind;

  assign text.ready    = !q_stat.full;
  assign fire          = text.valid && text.ready;
  assign c             = text.payload.in_byte;
  assign last          = text.payload.end_of_stream;
  assign is_ws         = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign is_dot        = (c == CHAR_DOT);
  assign is_dash       = (c == CHAR_DASH);
  assign is_slash      = (c == CHAR_SLASH);
  assign f_stat.halted = halted;

  // Token state after this byte; whitespace leaves it as is.
  always_comb begin
    symbol_bits_next   = symbol_bits;
    symbol_count_next  = symbol_count;
    bad_char_seen_next = bad_char_seen;
    slash_seen_next    = slash_seen;
    if (is_dot || is_dash) begin
      if (slash_seen) bad_char_seen_next = 1'b1;
      if (symbol_count < CNT_W'(MAX_SYMBOLS)) begin
        symbol_bits_next  = {symbol_bits[MAX_SYMBOLS-2:0], is_dash};
        symbol_count_next = symbol_count + CNT_W'(1);
      end else begin
        symbol_count_next = CNT_W'(MAX_SYMBOLS + 1);
      end
    end else if (is_slash) begin
      if (slash_seen || (symbol_count != '0)) bad_char_seen_next = 1'b1;
      slash_seen_next = 1'b1;
    end else if (!is_ws) begin
      bad_char_seen_next = 1'b1;
    end
  end

  // Judge the token as it stands after this byte.
  always_comb begin
    do_finish = !halted && (is_ws || last);
    pending   = (symbol_count_next != '0) || bad_char_seen_next || slash_seen_next;
    idx       = (IDX_W'(1) << symbol_count_next) + IDX_W'(symbol_bits_next[TABLE_SYMBOLS-1:0]);
    in_table  = !bad_char_seen_next && !slash_seen_next && (symbol_count_next != '0) &&
                (symbol_count_next <= CNT_W'(TABLE_SYMBOLS)) &&
                (symbol_count_next <= CNT_W'(MAX_SYMBOLS));
    if (slash_seen_next && !bad_char_seen_next && (symbol_count_next == '0)) begin
      kind = TOK_SPACE;
    end else if (in_table && (code_char(idx) != CHAR_NONE)) begin
      kind = TOK_CODE;
    end else begin
      kind = TOK_INVALID;
    end
    q_push        = fire && do_finish && pending;
    q_data.kind     = kind;
    q_data.code_idx = idx;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last)) begin
      symbol_bits   <= '0;
      symbol_count  <= '0;
      bad_char_seen <= 1'b0;
      slash_seen    <= 1'b0;
      halted        <= 1'b0;
    end else if (fire && do_finish) begin
      symbol_bits   <= '0;
      symbol_count  <= '0;
      bad_char_seen <= 1'b0;
      slash_seen    <= 1'b0;
      halted        <= pending && (kind == TOK_INVALID);
    end else if (fire && !halted) begin
      symbol_bits   <= symbol_bits_next;
      symbol_count  <= symbol_count_next;
      bad_char_seen <= bad_char_seen_next;
      slash_seen    <= slash_seen_next;
    end
  end

endmodule

// ===== rtl/mtd_queue.sv =====
// Two-entry queue of finished tokens between front end and back end.
// Depends on mtd_pkg.
module mtd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mtd_pkg::tok_entry_t push_data,
  input  logic                pop,
  output mtd_pkg::tok_entry_t pop_data,
  output mtd_pkg::q_stat_t    stat
);
  import mtd_pkg::*;

  tok_entry_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/mtd_back.sv =====
// Back end: turns queued tokens into characters and holds them in the output register.
// Depends on mtd_pkg and mtd_stream_if.
module mtd_back (
  input  logic                clk,
  input  logic                rst,
  input  mtd_pkg::tok_entry_t q_data,
  input  mtd_pkg::q_stat_t    q_stat,
  output logic                q_pop,
  mtd_stream_if.source        chars
);
  import mtd_pkg::*;

  logic      out_valid;
  out_item_t out_word, out_word_next;

  assign q_pop         = !q_stat.empty && (!out_valid || chars.ready);
  assign chars.valid   = out_valid;
  assign chars.payload = out_word;

  always_comb begin
    out_word_next.invalid_token = (q_data.kind == TOK_INVALID);
    unique case (q_data.kind)
      TOK_SPACE: out_word_next.decoded_char = CHAR_SPACE;
      TOK_CODE:  out_word_next.decoded_char = code_char(q_data.code_idx);
      default:   out_word_next.decoded_char = CHAR_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_word <= out_word_next;
  end

endmodule

// ===== rtl/morse_token_decoder.sv =====
// Top level of the Morse token decoder: front end, token queue and back end.
// Depends on mtd_pkg, mtd_stream_if, mtd_front, mtd_queue and mtd_back.
//
//   channel  dir  payload                        word
//   text     in   in_byte[7:0], end_of_stream    one text byte
//   chars    out  decoded_char[7:0], invalid_token  one decoded character
//
// Takes one byte per cycle while the token queue has room. A token result passes
// from the token queue into the output register, which drives chars.valid, provided
// the output register is free. The front end updates the token register and judges
// the code in the cycle a byte arrives; the back end maps it to its character as it
// leaves the queue. rst is synchronous, active high, and clears token state, halt
// flag, queue and output valid. text.ready drops only while the two-entry queue is
// full, which takes three finished tokens waiting behind a stalled chars.
module morse_token_decoder #(
  parameter int MAX_SYMBOLS = mtd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mtd_stream_if.sink   text,
  mtd_stream_if.source chars
);
  import mtd_pkg::*;

  // Queue handshake between the two halves.
  logic        q_push, q_pop;
  tok_entry_t  q_in, q_out;
  q_stat_t     q_stat;
  front_stat_t f_stat;

  // Classify bytes, build tokens, decide halting.
  mtd_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_in),
    .f_stat (f_stat)
  );

  // Decouple the front end from output stalls.
  mtd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // Look up characters and hold them until taken.
  mtd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_data (q_out),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .chars  (chars)
  );

`ifndef SYNTHESIS
  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("token pushed into full queue");

  // While halted, accepted bytes produce nothing.
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (f_stat.halted && text.valid && text.ready) |-> !q_push)
    else $error("token emitted while halted");

  // End of stream always releases the halt.
  a_eos_release: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.ready && text.payload.end_of_stream) |=> !f_stat.halted)
    else $error("halt not cleared at end of stream");
`endif

endmodule
